// File: rtl/vnl_pkg.sv
// Shared types, constants and tables of the vehicle noise level datapath.
package vnl_pkg;

  // Field widths and fixed-point formats.
  localparam int SPEED_W         = 12;
  localparam int CLASS_W         = 2;
  localparam int LEVEL_W         = 16;
  localparam int SPEED_FRAC_BITS = 4;
  localparam int LEVEL_FRAC_BITS = 8;
  localparam int Q_BITS          = 16;

  // Logarithm unit: exponent bits, Q30 mantissa and one squaring per fraction bit.
  localparam int LOG_E_W   = $clog2(SPEED_W);
  localparam int LOG_W     = LOG_E_W + Q_BITS;
  localparam int MANT_W    = 31;
  localparam int LOG_STEPS = Q_BITS;

  // Internal dB level, signed, 16 fraction bits.
  localparam int LVL_W = 28;
  typedef logic signed [LVL_W-1:0] level_t;

  typedef enum logic [CLASS_W-1:0] {
    CLASS_CAR     = 2'd0,
    CLASS_EV      = 2'd1,
    CLASS_MOTO    = 2'd2,
    CLASS_UNKNOWN = 2'd3
  } class_e;

  typedef struct packed {
    logic [SPEED_W-1:0] speed;
    class_e             vclass;
  } item_t;

  // Reference speed and log10(2) in Q16.
  localparam int VREF_KMH    = 70;
  localparam int VREF        = VREF_KMH << SPEED_FRAC_BITS;
  localparam int LOG10_2_Q16 = 19728;

  // Coefficients in tenths of dB.
  localparam int A_ROLL = 939;
  localparam int B_ROLL = 372;
  localparam int A_PROP_CAR  = 869;
  localparam int B_PROP_CAR  = 80;
  localparam int A_PROP_MOTO = 932;
  localparam int B_PROP_MOTO = 126;

  localparam int ROLL_GAIN_W = 24;
  localparam int PROP_BASE_W = 28;

  typedef struct packed {
    logic [9:0]             a_roll;
    logic [ROLL_GAIN_W-1:0] roll_gain;
    logic [PROP_BASE_W-1:0] prop_base;
    logic [6:0]             b_prop;
  } coef_t;

  // Per-class constants with the products against fixed factors folded in.
  function automatic coef_t class_coef(input class_e c);
    coef_t r;
    r = '0;
    unique case (c)
      CLASS_CAR: begin
        r.a_roll    = 10'(A_ROLL);
        r.roll_gain = ROLL_GAIN_W'(B_ROLL * LOG10_2_Q16);
        r.prop_base = PROP_BASE_W'(A_PROP_CAR * VREF);
        r.b_prop    = 7'(B_PROP_CAR);
      end
      CLASS_EV: begin
        r.a_roll    = 10'(A_ROLL);
        r.roll_gain = ROLL_GAIN_W'(B_ROLL * LOG10_2_Q16);
      end
      CLASS_MOTO: begin
        r.prop_base = PROP_BASE_W'(A_PROP_MOTO * VREF);
        r.b_prop    = 7'(B_PROP_MOTO);
      end
      CLASS_UNKNOWN: begin
        r = '0;
      end
      default: r = '0;
    endcase
    return r;
  endfunction

  // Elaboration-time log2 in Q16, same squaring rule as the hardware unit.
  function automatic logic [21:0] log2_q16(input logic [31:0] x);
    int          e;
    logic [63:0] m;
    logic [21:0] r;
    e = 0;
    m = '0;
    r = '0;
    for (int b = 0; b < 31; b++) begin
      if (x[b]) e = b;
    end
    if (x != '0) begin
      m = 64'(x) << (30 - e);
      r = 22'(e) << 16;
      for (int k = 15; k >= 0; k--) begin
        m = (m * m) >> 30;
        if (m >= 64'h8000_0000) begin
          m = m >> 1;
          r = r | (22'(1) << k);
        end
      end
    end
    return r;
  endfunction

  localparam logic [21:0] LOG2_VREF = log2_q16(32'(VREF));

  // Propulsion division: n * 2^16 / (10 * VREF) = n * 2^LP_SHIFT / LP_ODD.
  localparam int LP_ODD   = VREF_KMH * 10 / 4;
  localparam int LP_SHIFT = Q_BITS - 2 - SPEED_FRAC_BITS;
  localparam int N_MAX    = A_PROP_MOTO * VREF + B_PROP_MOTO * ((1 << SPEED_W) - 1);
  localparam int N_W      = $clog2(N_MAX + 1);
  localparam int NL_W     = N_W + LP_SHIFT;
  localparam int LP_K     = NL_W + 1;
  localparam int RECIP_W  = LP_K - 7;
  localparam int Q0_W     = NL_W - 7;
  localparam logic [RECIP_W-1:0] LP_RECIP = RECIP_W'((64'd1 << LP_K) / LP_ODD);

  // Rolling division: N / (10 * 2^16) = (N >> 17) / 5.
  localparam int LR_ODD   = 5;
  localparam int LR_SHIFT = 17;
  localparam int LR_A_W   = 30;
  localparam logic [29:0] LR_RECIP = 30'((64'd1 << 32) / LR_ODD);

  // Energetic sum gain 10*log10(1 + 10^(-d/10)), Q16, whole dB steps.
  localparam int GAIN_STEPS = 32;
  localparam int GAIN_W     = 18;
  localparam int GAIN_ZERO  = 197283;
  localparam logic [GAIN_W-1:0] GAIN_TABLE [GAIN_STEPS+1] = '{
    18'd197283, 18'd166398, 18'd139226, 18'd115628, 18'd95382, 18'd78205,
    18'd63782,  18'd51780,  18'd41872,  18'd33749,  18'd27127, 18'd21755,
    18'd17414,  18'd13919,  18'd11112,  18'd8861,   18'd7062,  18'd5623,
    18'd4476,   18'd3561,   18'd2832,   18'd2252,   18'd1790,  18'd1423,
    18'd1131,   18'd899,    18'd714,    18'd567,    18'd451,   18'd358,
    18'd285,    18'd226,    18'd0
  };

  // Output rounding.
  localparam int OUT_SHIFT = Q_BITS - LEVEL_FRAC_BITS;
  localparam int OUT_RND   = 1 << (OUT_SHIFT - 1);
  localparam int UNKNOWN_LEVEL = (GAIN_ZERO + OUT_RND) >> OUT_SHIFT;

  // Registers from start to the result strobe.
  localparam int PIPE_DEPTH = LOG_STEPS + 10;

endpackage

// File: rtl/vnl_log2.sv
// Pipelined log2 of the speed: normalize, then one mantissa squaring per stage.
module vnl_log2 (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      valid_i,
  input  vnl_pkg::item_t            item_i,
  output logic                      valid_o,
  output vnl_pkg::item_t            item_o,
  output logic [vnl_pkg::LOG_W-1:0] log_o
);

  localparam int N = vnl_pkg::LOG_STEPS;
  localparam int M = vnl_pkg::MANT_W;

  logic                            vld_q  [N+1];
  vnl_pkg::item_t                  item_q [N+1];
  logic [M-1:0]                    mant_q [N+1];
  logic [vnl_pkg::LOG_E_W-1:0]     exp_q  [N+1];
  logic [vnl_pkg::Q_BITS-1:0]      frac_q [N+1];

  logic [vnl_pkg::LOG_E_W-1:0]     exp_d;
  logic [M-1:0]                    mant_d;

  // Leading-one search and normalization to a Q30 mantissa in [1,2).
  always_comb begin
    exp_d = '0;
    for (int b = 0; b < vnl_pkg::SPEED_W; b++) begin
      if (item_i.speed[b]) exp_d = vnl_pkg::LOG_E_W'(b);
    end
    mant_d = M'(item_i.speed) << (5'(M - 1) - 5'(exp_d));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q[0] <= 1'b0;
    end else begin
      vld_q[0] <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    item_q[0] <= item_i;
    mant_q[0] <= mant_d;
    exp_q[0]  <= exp_d;
    frac_q[0] <= '0;
  end

  // Each stage squares the mantissa; an overflow past 2 gives one fraction bit.
  for (genvar j = 0; j < N; j++) begin : g_sq
    logic [2*M-1:0]              sq;
    logic [M:0]                  top;
    logic [M-1:0]                mant_n;
    logic [vnl_pkg::Q_BITS-1:0]  frac_n;

    always_comb begin
      sq     = (2*M)'(mant_q[j]) * (2*M)'(mant_q[j]);
      top    = sq[2*M-1:M-1];
      mant_n = top[M] ? top[M:1] : top[M-1:0];
      frac_n = frac_q[j];
      frac_n[vnl_pkg::Q_BITS-1-j] = top[M];
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[j+1] <= 1'b0;
      end else begin
        vld_q[j+1] <= vld_q[j];
      end
    end

    always_ff @(posedge clk_i) begin
      item_q[j+1] <= item_q[j];
      mant_q[j+1] <= mant_n;
      exp_q[j+1]  <= exp_q[j];
      frac_q[j+1] <= frac_n;
    end
  end

  assign valid_o = vld_q[N];
  assign item_o  = item_q[N];
  assign log_o   = {exp_q[N], frac_q[N]};

endmodule

// File: rtl/vehicle_noise_level.sv
// Vehicle noise level top level: class coefficients, levels, energetic sum, output.
//
// One vehicle item is taken per clock cycle whenever start is high; busy is
// always low. Each result appears on noise_level_o with valid_o high for one
// cycle, in input order. The result passes through the speed logarithm,
// which resolves one fraction bit per pipeline stage over 16 squaring
// stages, followed by the division, compare, table interpolation and
// rounding stages. The receiver cannot stall the block.
module vehicle_noise_level (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                start,
  output logic                                busy,
  input  logic [vnl_pkg::SPEED_W-1:0]         speed_i,
  input  logic [vnl_pkg::CLASS_W-1:0]         vehicle_class_i,
  output logic                                valid_o,
  output logic [vnl_pkg::LEVEL_W-1:0]         noise_level_o
);

  localparam int LW = vnl_pkg::LVL_W;

  // The pipeline advances every cycle, so a new transfer is always possible.
  assign busy = 1'b0;

  // Input register.
  logic           in_vld_q;
  vnl_pkg::item_t in_item_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else begin
      in_vld_q <= start && !busy;
    end
  end

  always_ff @(posedge clk_i) begin
    in_item_q <= '{speed: speed_i, vclass: vnl_pkg::class_e'(vehicle_class_i)};
  end

  // Speed logarithm.
  logic                      lg_vld;
  vnl_pkg::item_t            lg_item;
  logic [vnl_pkg::LOG_W-1:0] lg_log;

  vnl_log2 u_log2 (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (in_vld_q),
    .item_i  (in_item_q),
    .valid_o (lg_vld),
    .item_o  (lg_item),
    .log_o   (lg_log)
  );

  // Stage A: rolling slope product and propulsion numerator.
  vnl_pkg::coef_t             a_coef;
  logic signed [21:0]         a_dl;
  logic signed [46:0]         a_p_d;
  logic signed [19:0]         a_diff;
  logic signed [31:0]         a_n_full;
  logic                       a_vld_q;
  logic signed [46:0]         a_p_q;
  logic [9:0]                 a_roll_q;
  logic [vnl_pkg::N_W-1:0]    a_n_q;
  logic                       a_zero_q;

  always_comb begin
    a_coef   = vnl_pkg::class_coef(lg_item.vclass);
    a_dl     = $signed({{(22-vnl_pkg::LOG_W){1'b0}}, lg_log}) - $signed(vnl_pkg::LOG2_VREF);
    a_p_d    = 47'(a_dl) * 47'($signed({1'b0, a_coef.roll_gain}));
    a_diff   = $signed(20'(lg_item.speed)) - $signed(20'(vnl_pkg::VREF));
    // Nonnegative for every class and speed, so only the magnitude is kept.
    a_n_full = $signed(32'(a_coef.prop_base))
             + 32'($signed({1'b0, a_coef.b_prop})) * 32'(a_diff);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_vld_q <= 1'b0;
    end else begin
      a_vld_q <= lg_vld;
    end
  end

  always_ff @(posedge clk_i) begin
    a_p_q    <= a_p_d;
    a_roll_q <= a_coef.a_roll;
    a_n_q    <= a_n_full[vnl_pkg::N_W-1:0];
    a_zero_q <= (lg_item.speed == '0);
  end

  // Stage B: rolling numerator magnitude; propulsion reciprocal estimate.
  logic signed [47:0]                    b_num;
  logic [47:0]                           b_abs;
  logic [vnl_pkg::NL_W-1:0]              b_nl;
  logic [vnl_pkg::NL_W+vnl_pkg::RECIP_W-1:0] b_prod;
  logic                                  b_vld_q;
  logic [vnl_pkg::LR_A_W-1:0]            b_a_q;
  logic                                  b_neg_q;
  logic [vnl_pkg::NL_W-1:0]              b_nl_q;
  logic [vnl_pkg::Q0_W-1:0]              b_q0_q;
  logic                                  b_zero_q;

  always_comb begin
    b_num  = $signed({6'b0, a_roll_q, 32'b0}) + $signed({a_p_q[46], a_p_q});
    b_abs  = b_num[47] ? 48'(-b_num) : 48'(b_num);
    b_nl   = {a_n_q, {vnl_pkg::LP_SHIFT{1'b0}}};
    b_prod = (vnl_pkg::NL_W+vnl_pkg::RECIP_W)'(b_nl)
           * (vnl_pkg::NL_W+vnl_pkg::RECIP_W)'(vnl_pkg::LP_RECIP);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b_vld_q <= 1'b0;
    end else begin
      b_vld_q <= a_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    b_a_q    <= b_abs[vnl_pkg::LR_SHIFT +: vnl_pkg::LR_A_W];
    b_neg_q  <= b_num[47];
    b_nl_q   <= b_nl;
    b_q0_q   <= b_prod[vnl_pkg::LP_K +: vnl_pkg::Q0_W];
    b_zero_q <= a_zero_q;
  end

  // Stage C: rolling reciprocal estimate; propulsion quotient correction.
  logic [59:0]                c_prod;
  logic [vnl_pkg::NL_W:0]     c_back;
  logic [vnl_pkg::Q0_W-1:0]   c_lpq;
  logic                       c_vld_q;
  logic [27:0]                c_q0_q;
  logic [vnl_pkg::LR_A_W-1:0] c_a_q;
  logic                       c_neg_q;
  vnl_pkg::level_t            c_lp_q;
  logic                       c_zero_q;

  always_comb begin
    c_prod = 60'(b_a_q) * 60'(vnl_pkg::LR_RECIP);
    c_back = (vnl_pkg::NL_W+1)'(b_q0_q) * (vnl_pkg::NL_W+1)'(vnl_pkg::LP_ODD)
           + (vnl_pkg::NL_W+1)'(vnl_pkg::LP_ODD);
    c_lpq  = ((vnl_pkg::NL_W+1)'(b_nl_q) >= c_back) ? b_q0_q + 1'b1 : b_q0_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      c_vld_q <= 1'b0;
    end else begin
      c_vld_q <= b_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    c_q0_q   <= c_prod[59:32];
    c_a_q    <= b_a_q;
    c_neg_q  <= b_neg_q;
    c_lp_q   <= vnl_pkg::level_t'(c_lpq);
    c_zero_q <= b_zero_q;
  end

  // Stage D: rolling quotient correction and sign, truncating toward zero.
  logic [30:0]     d_back;
  logic [27:0]     d_q;
  vnl_pkg::level_t d_mag;
  logic            d_vld_q;
  vnl_pkg::level_t d_lr_q;
  vnl_pkg::level_t d_lp_q;
  logic            d_zero_q;

  always_comb begin
    d_back = 31'(c_q0_q) * 31'(vnl_pkg::LR_ODD) + 31'(vnl_pkg::LR_ODD);
    d_q    = (31'(c_a_q) >= d_back) ? c_q0_q + 1'b1 : c_q0_q;
    d_mag  = vnl_pkg::level_t'(d_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      d_vld_q <= 1'b0;
    end else begin
      d_vld_q <= c_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    d_lr_q   <= c_neg_q ? -d_mag : d_mag;
    d_lp_q   <= c_lp_q;
    d_zero_q <= c_zero_q;
  end

  // Stage E: larger level and level difference.
  vnl_pkg::level_t e_hi;
  vnl_pkg::level_t e_lo;
  logic            e_vld_q;
  vnl_pkg::level_t e_hi_q;
  logic [LW-1:0]   e_d_q;
  vnl_pkg::level_t e_lp_q;
  logic            e_zero_q;

  always_comb begin
    e_hi = (d_lr_q > d_lp_q) ? d_lr_q : d_lp_q;
    e_lo = (d_lr_q > d_lp_q) ? d_lp_q : d_lr_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      e_vld_q <= 1'b0;
    end else begin
      e_vld_q <= d_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    e_hi_q   <= e_hi;
    e_d_q    <= LW'(e_hi - e_lo);
    e_lp_q   <= d_lp_q;
    e_zero_q <= d_zero_q;
  end

  // Stage F: gain table lookup and interpolation product.
  logic [4:0]                   f_idx;
  logic [vnl_pkg::GAIN_W-1:0]   f_t0;
  logic [vnl_pkg::GAIN_W-1:0]   f_t1;
  logic [vnl_pkg::GAIN_W+15:0]  f_prod;
  logic                         f_vld_q;
  logic [vnl_pkg::GAIN_W-1:0]   f_t0_q;
  logic [vnl_pkg::GAIN_W-1:0]   f_pr_q;
  logic                         f_big_q;
  vnl_pkg::level_t              f_hi_q;
  vnl_pkg::level_t              f_lp_q;
  logic                         f_zero_q;

  always_comb begin
    f_idx  = e_d_q[vnl_pkg::Q_BITS +: 5];
    f_t0   = vnl_pkg::GAIN_TABLE[{1'b0, f_idx}];
    f_t1   = vnl_pkg::GAIN_TABLE[{1'b0, f_idx} + 6'd1];
    f_prod = (vnl_pkg::GAIN_W+16)'(f_t0 - f_t1)
           * (vnl_pkg::GAIN_W+16)'(e_d_q[vnl_pkg::Q_BITS-1:0]);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      f_vld_q <= 1'b0;
    end else begin
      f_vld_q <= e_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    f_t0_q   <= f_t0;
    f_pr_q   <= f_prod[vnl_pkg::Q_BITS +: vnl_pkg::GAIN_W];
    // A difference of 32 dB or more adds no energy.
    f_big_q  <= |e_d_q[LW-1:vnl_pkg::Q_BITS+5];
    f_hi_q   <= e_hi_q;
    f_lp_q   <= e_lp_q;
    f_zero_q <= e_zero_q;
  end

  // Stage G: energetic sum; at zero speed only the propulsion term counts.
  logic [vnl_pkg::GAIN_W-1:0] g_gain;
  logic                       g_vld_q;
  vnl_pkg::level_t            g_lvl_q;

  always_comb begin
    g_gain = f_big_q ? '0 : f_t0_q - f_pr_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      g_vld_q <= 1'b0;
    end else begin
      g_vld_q <= f_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    g_lvl_q <= f_zero_q ? f_lp_q : f_hi_q + vnl_pkg::level_t'(g_gain);
  end

  // Stage H: clamp at zero, round to the output format and saturate.
  logic [LW-1:0]              h_sum;
  logic [LW-1:0]              h_q;
  logic [vnl_pkg::LEVEL_W-1:0] h_out;
  logic                       out_vld_q;
  logic [vnl_pkg::LEVEL_W-1:0] out_lvl_q;

  always_comb begin
    h_sum = LW'(g_lvl_q) + LW'(vnl_pkg::OUT_RND);
    h_q   = h_sum >> vnl_pkg::OUT_SHIFT;
    if (g_lvl_q[LW-1]) begin
      h_out = '0;
    end else if (|h_q[LW-1:vnl_pkg::LEVEL_W]) begin
      h_out = '1;
    end else begin
      h_out = h_q[vnl_pkg::LEVEL_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else begin
      out_vld_q <= g_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    out_lvl_q <= h_out;
  end

  assign valid_o       = out_vld_q;
  assign noise_level_o = out_lvl_q;

`ifndef SYNTHESIS
  // Every transfer yields exactly one result after the fixed latency.
  a_start_to_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |-> ##(vnl_pkg::PIPE_DEPTH) valid_o)
    else $error("transfer did not produce a result at the expected latency");

  a_result_has_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> $past(start && !busy, vnl_pkg::PIPE_DEPTH))
    else $error("result strobe without a matching transfer");

  // Unknown class at nonzero speed sums two 0 dB terms.
  a_unknown_level: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_o && ($past(vehicle_class_i, vnl_pkg::PIPE_DEPTH) == vnl_pkg::CLASS_UNKNOWN)
      && ($past(speed_i, vnl_pkg::PIPE_DEPTH) != '0))
    |-> (noise_level_o == vnl_pkg::LEVEL_W'(vnl_pkg::UNKNOWN_LEVEL)))
    else $error("unknown class level differs from the 0 dB energetic sum");

  // Without a propulsion term, zero speed gives zero level.
  a_zero_speed_silent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_o && ($past(speed_i, vnl_pkg::PIPE_DEPTH) == '0)
      && (($past(vehicle_class_i, vnl_pkg::PIPE_DEPTH) == vnl_pkg::CLASS_UNKNOWN)
       || ($past(vehicle_class_i, vnl_pkg::PIPE_DEPTH) == vnl_pkg::CLASS_EV)))
    |-> (noise_level_o == '0))
    else $error("zero speed without propulsion gave a nonzero level");
`endif

endmodule
